@@ design/layered_bfs_node_controller_top_assert.svh @@
`ifndef LAYERED_BFS_NODE_CONTROLLER_TOP_ASSERT_SVH
`define LAYERED_BFS_NODE_CONTROLLER_TOP_ASSERT_SVH
// assertion helpers for the node controller
`define LBN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbn check failed");
`define LBN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbn check failed");
`endif

@@ design/lbn_pkg.sv @@
package lbn_pkg;
  localparam int MaxPortsDef = 8;

  typedef enum logic [2:0] {
    REQ_START = 3'd0, REQ_SEARCH = 3'd1, REQ_NEWPHASE = 3'd2, REQ_ACK = 3'd3,
    REQ_NACK = 3'd4, REQ_TERM = 3'd5, REQ_INFO = 3'd6, REQ_NONE = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    MSG_SEARCH = 3'd0, MSG_NEWPHASE = 3'd1, MSG_ACK = 3'd2, MSG_NACK = 3'd3,
    MSG_TERM = 3'd4, MSG_INFO = 3'd5
  } msg_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_FAN, ST_DONE
  } state_t;

  // fan-out modes
  typedef enum logic [1:0] {
    FAN_ALL, FAN_SKIP_PARENT, FAN_CHILDREN
  } fan_t;

  typedef struct packed {
    logic load;
    logic step;
    logic emit;
    logic emit_status;
  } ctl_t;

  typedef struct packed {
    logic fan_any;
    logic fan_valid;
    logic fan_last;
    logic single;
  } sts_t;
endpackage

@@ design/lbn_datapath.sv @@
module lbn_datapath
  import lbn_pkg::*;
#(
  parameter int MAX_PORTS = MaxPortsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] node_uid,
  input  logic        is_root,
  input  logic [3:0]  nb_count,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_src_port,
  input  logic [7:0]  in_msg_layer,
  input  logic        in_msg_discovered,
  input  logic [3:0]  in_msg_degree,
  input  ctl_t        ctl,
  output sts_t        sts,
  output logic        out_strobe,
  output logic        out_has_message,
  output logic [2:0]  out_out_type,
  output logic [2:0]  out_dst_port,
  output logic [15:0] out_sender_uid,
  output logic [7:0]  out_out_layer,
  output logic        out_out_discovered,
  output logic [3:0]  out_out_degree,
  output logic        out_finished,
  output logic        out_last
);
  localparam int CapPorts = (MAX_PORTS < 8) ? MAX_PORTS : 8;

  logic        marked_r, found_r, done_r;
  logic [7:0]  tlayer_r, player_r;
  logic [2:0]  parent_r;
  logic [3:0]  ccount_r, outst_r, maxdeg_r;
  logic [2:0]  clist_r [8];

  // pending fan-out
  fan_t        fmode_r;
  msg_t        ftype_r;
  logic [7:0]  flayer_r;
  logic [3:0]  fidx_r, fend_r;
  logic [2:0]  fskip_r;
  // pending single message
  logic        s_has_r;
  msg_t        s_type_r;
  logic [2:0]  s_dst_r;
  logic [7:0]  s_layer_r;
  logic        s_disc_r;
  logic [3:0]  s_deg_r;

  logic [3:0] np;
  always_comb begin
    np = (nb_count > 4'(CapPorts)) ? 4'(CapPorts) : nb_count;
  end

  // skip index when excluding parent
  logic [3:0] fidx_eff;
  logic       fan_valid;
  always_comb begin
    fidx_eff = fidx_r;
    if (fmode_r == FAN_SKIP_PARENT && fidx_r == {1'b0, fskip_r}) fidx_eff = fidx_r + 4'd1;
    fan_valid = fidx_eff < fend_r;
  end
  logic [3:0] fidx_next;
  logic       fan_last;
  always_comb begin
    fidx_next = fidx_eff + 4'd1;
    if (fmode_r == FAN_SKIP_PARENT && fidx_next == {1'b0, fskip_r}) fidx_next = fidx_next + 4'd1;
    fan_last = fidx_next >= fend_r;
  end

  assign sts.fan_any   = fan_valid;
  assign sts.fan_valid = fan_valid;
  assign sts.fan_last  = fan_last;
  assign sts.single    = s_has_r;

  // decode of an item, on the load strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marked_r <= 1'b0; found_r <= 1'b0; done_r <= 1'b0;
      tlayer_r <= '0; player_r <= '0; parent_r <= '0;
      ccount_r <= '0; outst_r <= '0; maxdeg_r <= '0;
      fidx_r <= '0; fend_r <= '0; s_has_r <= 1'b0;
      fmode_r <= FAN_ALL; ftype_r <= MSG_SEARCH; flayer_r <= '0; fskip_r <= '0;
      s_type_r <= MSG_NACK; s_dst_r <= '0; s_layer_r <= '0; s_disc_r <= 1'b0;
      s_deg_r <= '0;
    end else if (ctl.load) begin
      logic [3:0] o;
      logic [3:0] cc;
      logic       fn;
      logic [3:0] md, nd;
      fidx_r <= '0; fend_r <= '0; s_has_r <= 1'b0;
      fmode_r <= FAN_ALL; fskip_r <= parent_r;
      s_disc_r <= 1'b0; s_deg_r <= '0;
      o = outst_r; cc = ccount_r; fn = found_r; md = maxdeg_r;
      unique case (req_t'(in_req_type))
        REQ_START: if (is_root) begin
          marked_r <= 1'b1; tlayer_r <= '0; player_r <= 8'd1;
          ccount_r <= '0; maxdeg_r <= '0; done_r <= (np == 4'd0); found_r <= 1'b0;
          ftype_r <= MSG_SEARCH; flayer_r <= 8'd1; fend_r <= np; outst_r <= np;
        end
        REQ_SEARCH: begin
          s_has_r <= 1'b1; s_dst_r <= in_src_port; s_layer_r <= in_msg_layer;
          if (marked_r) s_type_r <= MSG_NACK;
          else begin
            marked_r <= 1'b1; parent_r <= in_src_port; tlayer_r <= in_msg_layer;
            found_r <= 1'b1; s_type_r <= MSG_ACK; s_disc_r <= 1'b1;
          end
        end
        REQ_NEWPHASE: begin
          found_r <= 1'b0; player_r <= in_msg_layer;
          if ({1'b0, in_msg_layer} == {1'b0, tlayer_r} + 9'd1) begin
            logic [3:0] cnt;
            cnt = np - ((parent_r < np[2:0] || np == 4'd8) ? 4'd1 : 4'd0);
            if ({1'b0, parent_r} >= np) cnt = np;
            ftype_r <= MSG_SEARCH; flayer_r <= in_msg_layer; fend_r <= np;
            fmode_r <= FAN_SKIP_PARENT; outst_r <= cnt;
            if (cnt == 4'd0) begin
              if (is_root) begin
                ftype_r <= MSG_TERM; flayer_r <= in_msg_layer; fend_r <= ccount_r;
                fmode_r <= FAN_CHILDREN; outst_r <= ccount_r;
                if (ccount_r == 4'd0) done_r <= 1'b1;
              end else begin
                s_has_r <= 1'b1; s_type_r <= MSG_NACK; s_dst_r <= parent_r;
                s_layer_r <= in_msg_layer; s_disc_r <= 1'b0;
              end
            end
          end else if (ccount_r == 4'd0) begin
            outst_r <= '0;
            s_has_r <= 1'b1; s_type_r <= MSG_NACK; s_dst_r <= in_src_port;
            s_layer_r <= in_msg_layer;
          end else begin
            ftype_r <= MSG_NEWPHASE; flayer_r <= in_msg_layer; fend_r <= ccount_r;
            fmode_r <= FAN_CHILDREN; outst_r <= ccount_r;
          end
        end
        REQ_ACK, REQ_NACK: if (outst_r != 4'd0) begin
          o = outst_r - 4'd1;
          outst_r <= o;
          if (in_req_type == REQ_ACK && cc < np) begin
            clist_r[cc[2:0]] <= in_src_port;
            cc = cc + 4'd1;
            ccount_r <= cc;
          end
          if (in_msg_discovered) fn = 1'b1;
          found_r <= fn;
          if (o == 4'd0) begin
            if (is_root) begin
              if (fn && player_r < 8'd255 && np != 4'd0) begin
                player_r <= player_r + 8'd1; found_r <= 1'b0;
                ftype_r <= MSG_NEWPHASE; flayer_r <= player_r + 8'd1;
                fend_r <= np; outst_r <= np;
              end else begin
                ftype_r <= MSG_TERM; flayer_r <= player_r; fend_r <= cc;
                fmode_r <= FAN_CHILDREN; outst_r <= cc;
                if (cc == 4'd0) done_r <= 1'b1;
              end
            end else begin
              s_has_r <= 1'b1; s_type_r <= MSG_NACK; s_dst_r <= parent_r;
              s_layer_r <= in_msg_layer; s_disc_r <= fn;
            end
          end
        end
        REQ_TERM: begin
          if (ccount_r != 4'd0) begin
            ftype_r <= MSG_TERM; flayer_r <= in_msg_layer; fend_r <= ccount_r;
            fmode_r <= FAN_CHILDREN; outst_r <= ccount_r;
          end else begin
            outst_r <= '0;
            s_has_r <= 1'b1; s_type_r <= MSG_INFO; s_dst_r <= in_src_port;
            s_layer_r <= in_msg_layer; s_deg_r <= 4'd1; done_r <= 1'b1;
          end
        end
        REQ_INFO: if (outst_r != 4'd0) begin
          o = outst_r - 4'd1;
          outst_r <= o;
          if (in_msg_degree > md) md = in_msg_degree;
          maxdeg_r <= md;
          if (o == 4'd0) begin
            nd = ccount_r + 4'd1;
            done_r <= 1'b1;
            if (!is_root) begin
              s_has_r <= 1'b1; s_type_r <= MSG_INFO; s_dst_r <= parent_r;
              s_layer_r <= in_msg_layer; s_deg_r <= (nd > md) ? nd : md;
            end
          end
        end
        default: ;
      endcase
    end else if (ctl.step) begin
      if (s_has_r) s_has_r <= 1'b0;
      else fidx_r <= fidx_next;
    end
  end

  // ---- output register ----
  logic [2:0] fan_dst;
  always_comb begin
    fan_dst = (fmode_r == FAN_CHILDREN) ? clist_r[fidx_eff[2:0]] : fidx_eff[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= ctl.emit | ctl.emit_status;
    end
  end

  always_ff @(posedge clk) begin
    out_finished <= done_r;
    if (ctl.emit_status) begin
      out_has_message <= 1'b0; out_out_type <= '0; out_dst_port <= '0;
      out_sender_uid <= '0; out_out_layer <= '0; out_out_discovered <= 1'b0;
      out_out_degree <= '0; out_last <= 1'b1;
    end else if (s_has_r) begin
      out_has_message <= 1'b1; out_out_type <= s_type_r; out_dst_port <= s_dst_r;
      out_sender_uid <= node_uid;
      out_out_layer <= s_layer_r; out_out_discovered <= s_disc_r;
      out_out_degree <= s_deg_r; out_last <= 1'b1;
    end else begin
      out_has_message <= 1'b1; out_out_type <= ftype_r; out_dst_port <= fan_dst;
      out_sender_uid <= node_uid;
      out_out_layer <= flayer_r; out_out_discovered <= 1'b0;
      out_out_degree <= '0; out_last <= fan_last;
    end
  end
endmodule

@@ design/lbn_ctrl.sv @@
module lbn_ctrl
  import lbn_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output ctl_t ctl
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    ctl = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: if (start) begin
        ctl.load = 1'b1;
        state_nxt = ST_FAN;
      end
      ST_FAN: begin
        if (sts.single) begin
          ctl.emit = 1'b1; ctl.step = 1'b1; state_nxt = ST_DONE;
        end else if (sts.fan_valid) begin
          ctl.emit = 1'b1; ctl.step = 1'b1;
          if (sts.fan_last) state_nxt = ST_DONE;
        end else begin
          ctl.emit_status = 1'b1; state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

@@ design/layered_bfs_node_controller_top.sv @@
// One node of a layered BFS spanning-tree protocol. Pulse start with a
// received message while busy is low; the node then drives its outgoing
// messages, one per cycle on out_strobe, with out_last on the final one.
// The receiver cannot stall, so every beat must be taken when strobed.
// A message is decoded first, then its results (one to eight, from the
// datapath's port fan-out) are driven, then the controller passes a settle
// state before busy drops, so a new message is taken only after the last.
module layered_bfs_node_controller_top
  import lbn_pkg::*;
#(
  parameter int MAX_PORTS = MaxPortsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_src_port,
  input  logic [7:0]  in_msg_layer,
  input  logic        in_msg_discovered,
  input  logic [3:0]  in_msg_degree,
  output logic        out_strobe,
  output logic        out_has_message,
  output logic [2:0]  out_out_type,
  output logic [2:0]  out_dst_port,
  output logic [15:0] out_sender_uid,
  output logic [7:0]  out_out_layer,
  output logic        out_out_discovered,
  output logic [3:0]  out_out_degree,
  output logic        out_finished,
  output logic        out_last
);
  logic [15:0] uid_r;
  logic        root_r;
  logic [3:0]  nbc_r;
  ctl_t        ctl;
  sts_t        sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uid_r <= '0; root_r <= 1'b0; nbc_r <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        2'd0: uid_r <= cfg_data;
        2'd1: root_r <= cfg_data[0];
        2'd2: nbc_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lbn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sts(sts), .ctl(ctl)
  );

  lbn_datapath #(.MAX_PORTS(MAX_PORTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .node_uid(uid_r), .is_root(root_r), .nb_count(nbc_r),
    .in_req_type(in_req_type), .in_src_port(in_src_port), .in_msg_layer(in_msg_layer),
    .in_msg_discovered(in_msg_discovered), .in_msg_degree(in_msg_degree),
    .ctl(ctl), .sts(sts), .out_strobe(out_strobe), .out_has_message(out_has_message),
    .out_out_type(out_out_type), .out_dst_port(out_dst_port),
    .out_sender_uid(out_sender_uid), .out_out_layer(out_out_layer),
    .out_out_discovered(out_out_discovered), .out_out_degree(out_out_degree),
    .out_finished(out_finished), .out_last(out_last)
  );
endmodule

@@ design/lbn_checker.sv @@
`include "layered_bfs_node_controller_top_assert.svh"
module lbn_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input logic out_has_message,
  input logic out_last,
  input logic [2:0] out_out_type
);
  `LBN_ASSERT_IMPL(a_no_beat_idle, out_strobe, $past(busy))
  `LBN_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
  `LBN_ASSERT_IMPL(a_status_last, out_strobe && !out_has_message, out_last)
  `LBN_ASSERT_IMPL(a_type_range, out_strobe && out_has_message, out_out_type <= 3'd5)
endmodule

bind layered_bfs_node_controller_top lbn_checker u_lbn_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_strobe(out_strobe),
  .out_has_message(out_has_message), .out_last(out_last), .out_out_type(out_out_type)
);

@@ sim/tb_top.sv @@
module tb_top;
  import lbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UID   = 2'd0;
  localparam logic [1:0] REG_ROOT  = 2'd1;
  localparam logic [1:0] REG_PORTS = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS = 250;

  typedef struct {
    logic        has_message;
    logic [2:0]  out_type;
    logic [2:0]  dst_port;
    logic [15:0] sender_uid;
    logic [7:0]  out_layer;
    logic        out_discovered;
    logic [3:0]  out_degree;
    logic        finished;
    logic        last;
  } beat_t;

  typedef enum logic { ROW_CFG, ROW_MSG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [2:0]  code;
    logic [15:0] value;
    logic [2:0]  src;
    logic [7:0]  layer;
    logic        disc;
    logic [3:0]  degree;
    int          want_beats;
    msg_t        want_type;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        start;
  logic        busy;
  logic [2:0]  in_req_type;
  logic [2:0]  in_src_port;
  logic [7:0]  in_msg_layer;
  logic        in_msg_discovered;
  logic [3:0]  in_msg_degree;
  logic        out_strobe;
  logic        out_has_message;
  logic [2:0]  out_out_type;
  logic [2:0]  out_dst_port;
  logic [15:0] out_sender_uid;
  logic [7:0]  out_out_layer;
  logic        out_out_discovered;
  logic [3:0]  out_out_degree;
  logic        out_finished;
  logic        out_last;

  layered_bfs_node_controller_top u_dut (.*);

  // node model state
  logic [15:0] m_uid;
  logic        m_root;
  logic [3:0]  m_nports;
  logic        m_marked;
  logic [7:0]  m_tree_layer;
  logic [7:0]  m_phase_layer;
  logic [2:0]  m_parent;
  logic [2:0]  m_children [8];
  int          m_child_count;
  int          m_outstanding;
  logic        m_found_new;
  logic [3:0]  m_max_degree;
  logic        m_done;

  beat_t step_beats[$];
  beat_t pending_beats[$];
  int    errors = 0;
  int    idle_pct = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  function automatic int ports_used();
    return (m_nports > 4'd8) ? 8 : int'(m_nports);
  endfunction

  function automatic void emit(msg_t ty, logic [2:0] dst, logic [7:0] lay, logic disc,
                               logic [3:0] deg);
    beat_t b;
    if (step_beats.size() >= 8) return;
    b.has_message = 1'b1;
    b.out_type = ty;
    b.dst_port = dst;
    b.sender_uid = m_uid;
    b.out_layer = lay;
    b.out_discovered = disc;
    b.out_degree = deg;
    b.finished = 1'b0;
    b.last = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void root_next_phase();
    int np;
    np = ports_used();
    if (m_found_new && m_phase_layer < 8'd255 && np > 0) begin
      m_phase_layer++;
      m_found_new = 1'b0;
      for (int i = 0; i < np; i++) emit(MSG_NEWPHASE, 3'(i), m_phase_layer, 1'b0, 4'd0);
      m_outstanding = np;
    end else begin
      for (int i = 0; i < m_child_count; i++)
        emit(MSG_TERM, m_children[i], m_phase_layer, 1'b0, 4'd0);
      m_outstanding = m_child_count;
      if (m_child_count == 0) m_done = 1'b1;
    end
  endfunction

  function automatic void phase_end(logic [7:0] lay);
    if (m_root) root_next_phase();
    else emit(MSG_NACK, m_parent, lay, m_found_new, 4'd0);
  endfunction

  function automatic void node_step(req_t ty, logic [2:0] src, logic [7:0] lay, logic disc,
                                    logic [3:0] deg);
    int np;
    int nd;
    beat_t b;
    np = ports_used();
    step_beats.delete();
    case (ty)
      REQ_START: begin
        if (m_root) begin
          m_marked = 1'b1;
          m_tree_layer = 8'd0;
          m_phase_layer = 8'd1;
          m_child_count = 0;
          m_max_degree = 4'd0;
          m_done = 1'b0;
          m_found_new = 1'b0;
          for (int i = 0; i < np; i++) emit(MSG_SEARCH, 3'(i), 8'd1, 1'b0, 4'd0);
          m_outstanding = np;
          if (np == 0) root_next_phase();
        end
      end
      REQ_SEARCH: begin
        if (m_marked) begin
          emit(MSG_NACK, src, lay, 1'b0, 4'd0);
        end else begin
          m_marked = 1'b1;
          m_parent = src;
          m_tree_layer = lay;
          m_found_new = 1'b1;
          emit(MSG_ACK, src, lay, 1'b1, 4'd0);
        end
      end
      REQ_NEWPHASE: begin
        m_found_new = 1'b0;
        m_outstanding = 0;
        m_phase_layer = lay;
        if (int'(lay) == int'(m_tree_layer) + 1) begin
          for (int i = 0; i < np; i++) begin
            if (3'(i) != m_parent || i > 7) begin
              emit(MSG_SEARCH, 3'(i), lay, 1'b0, 4'd0);
              m_outstanding++;
            end
          end
          if (m_outstanding == 0) phase_end(lay);
        end else if (m_child_count == 0) begin
          emit(MSG_NACK, src, lay, 1'b0, 4'd0);
        end else begin
          for (int i = 0; i < m_child_count; i++)
            emit(MSG_NEWPHASE, m_children[i], lay, 1'b0, 4'd0);
          m_outstanding = m_child_count;
        end
      end
      REQ_ACK, REQ_NACK: begin
        if (m_outstanding != 0) begin
          m_outstanding--;
          if (ty == REQ_ACK && m_child_count < np && m_child_count < 8) begin
            m_children[m_child_count] = src;
            m_child_count++;
          end
          if (disc) m_found_new = 1'b1;
          if (m_outstanding == 0) phase_end(lay);
        end
      end
      REQ_TERM: begin
        m_outstanding = 0;
        if (m_child_count > 0) begin
          for (int i = 0; i < m_child_count; i++)
            emit(MSG_TERM, m_children[i], lay, 1'b0, 4'd0);
          m_outstanding = m_child_count;
        end else begin
          emit(MSG_INFO, src, lay, 1'b0, 4'd1);
          m_done = 1'b1;
        end
      end
      REQ_INFO: begin
        if (m_outstanding != 0) begin
          m_outstanding--;
          if (deg > m_max_degree) m_max_degree = deg;
          if (m_outstanding == 0) begin
            nd = m_child_count + 1;
            if (int'(m_max_degree) > nd) nd = int'(m_max_degree);
            if (!m_root) emit(MSG_INFO, m_parent, lay, 1'b0, 4'(nd));
            m_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (step_beats.size() == 0) begin
      b = '{default: '0};
      step_beats.push_back(b);
    end
    foreach (step_beats[k]) begin
      step_beats[k].finished = m_done;
      step_beats[k].last = (k == step_beats.size() - 1);
    end
  endfunction

  always @(posedge clk) begin
    beat_t e;
    if (rst_n && out_strobe) begin
      if (pending_beats.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        e = pending_beats.pop_front();
        if (out_has_message !== e.has_message)
          report_mismatch($sformatf("has_message %b want %b", out_has_message, e.has_message));
        if (out_out_type !== e.out_type)
          report_mismatch($sformatf("out_type %0d want %0d", out_out_type, e.out_type));
        if (out_dst_port !== e.dst_port)
          report_mismatch($sformatf("dst_port %0d want %0d", out_dst_port, e.dst_port));
        if (out_sender_uid !== e.sender_uid)
          report_mismatch($sformatf("sender_uid %h want %h", out_sender_uid, e.sender_uid));
        if (out_out_layer !== e.out_layer)
          report_mismatch($sformatf("out_layer %0d want %0d", out_out_layer, e.out_layer));
        if (out_out_discovered !== e.out_discovered)
          report_mismatch($sformatf("out_discovered %b want %b", out_out_discovered,
                                    e.out_discovered));
        if (out_out_degree !== e.out_degree)
          report_mismatch($sformatf("out_degree %0d want %0d", out_out_degree, e.out_degree));
        if (out_finished !== e.finished)
          report_mismatch($sformatf("finished %b want %b", out_finished, e.finished));
        if (out_last !== e.last)
          report_mismatch($sformatf("last %b want %b", out_last, e.last));
      end
    end
  end

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_UID:   m_uid = val;
      REG_ROOT:  m_root = val[0];
      REG_PORTS: m_nports = val[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_beat(input logic [2:0] ty, input logic [2:0] src, input logic [7:0] lay,
                           input logic disc, input logic [3:0] deg, output int nbeats,
                           output logic [2:0] first_type);
    start <= 1'b1;
    in_req_type <= ty;
    in_src_port <= src;
    in_msg_layer <= lay;
    in_msg_discovered <= disc;
    in_msg_degree <= deg;
    do @(posedge clk); while (busy !== 1'b0);
    node_step(req_t'(ty), src, lay, disc, deg);
    nbeats = step_beats.size();
    first_type = step_beats[0].out_type;
    foreach (step_beats[k]) pending_beats.push_back(step_beats[k]);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  function automatic void pick_item(output logic [2:0] ty, output logic [2:0] src,
                                    output logic [7:0] lay, output logic disc,
                                    output logic [3:0] deg);
    int r;
    int np;
    r = $urandom_range(99);
    np = ports_used();
    ty = 3'($urandom_range(7));
    src = (np > 0 && $urandom_range(3) != 0) ? 3'($urandom_range(np - 1)) : 3'($urandom);
    lay = 8'($urandom);
    disc = 1'($urandom);
    deg = 4'($urandom);
    if (r < 10) return;
    if (m_root && (!m_marked || m_done || r < 15)) begin
      ty = REQ_START;
    end else if (!m_root && !m_marked) begin
      ty = REQ_SEARCH;
    end else if (m_outstanding > 0) begin
      if (r < 55) ty = REQ_ACK;
      else if (r < 75) ty = REQ_NACK;
      else if (r < 90) ty = REQ_INFO;
      else ty = REQ_NEWPHASE;
      if ($urandom_range(1) == 0) lay = m_phase_layer;
    end else if (!m_root) begin
      if (r < 60) begin
        ty = REQ_NEWPHASE;
        lay = ($urandom_range(1) == 0) ? m_tree_layer + 8'd1 : m_phase_layer + 8'd1;
      end else if (r < 80) begin
        ty = REQ_TERM;
      end else begin
        ty = REQ_SEARCH;
      end
    end
  endfunction

  row_t rows[$];

  function automatic row_t cfg_row(logic [1:0] idx, logic [15:0] val);
    return '{ROW_CFG, 3'(idx), val, 3'd0, 8'd0, 1'b0, 4'd0, 0, MSG_SEARCH};
  endfunction

  function automatic row_t msg_row(req_t ty, logic [2:0] src, logic [7:0] lay, logic disc,
                                   logic [3:0] deg, int nb = 0, msg_t mt = MSG_SEARCH);
    return '{ROW_MSG, ty, 16'd0, src, lay, disc, deg, nb, mt};
  endfunction

  initial begin
    int nb;
    logic [2:0] ft;
    logic [2:0] ty;
    logic [2:0] src;
    logic [7:0] lay;
    logic disc;
    logic [3:0] deg;
    int idle_plan[4] = '{0, 51, 0, 38};

    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    start = 1'b0;
    in_req_type = '0;
    in_src_port = '0;
    in_msg_layer = '0;
    in_msg_discovered = 1'b0;
    in_msg_degree = '0;

    m_uid = '0;
    m_root = 1'b0;
    m_nports = 4'd1;
    m_marked = 1'b0;
    m_tree_layer = '0;
    m_phase_layer = '0;
    m_parent = '0;
    foreach (m_children[i]) m_children[i] = '0;
    m_child_count = 0;
    m_outstanding = 0;
    m_found_new = 1'b0;
    m_max_degree = '0;
    m_done = 1'b0;

    rows = '{
      msg_row(REQ_START, 3'd0, 8'd0, 1'b0, 4'd0, 1),
      msg_row(REQ_NONE, 3'd7, 8'd255, 1'b1, 4'd15, 1),
      msg_row(REQ_ACK, 3'd0, 8'd0, 1'b1, 4'd0, 1),
      cfg_row(REG_UID, 16'hA5C3),
      cfg_row(REG_SPARE, 16'hFFFF),
      msg_row(REQ_SEARCH, 3'd0, 8'd3, 1'b0, 4'd0, 1, MSG_ACK),
      msg_row(REQ_SEARCH, 3'd7, 8'd3, 1'b0, 4'd0, 1, MSG_NACK),
      msg_row(REQ_NEWPHASE, 3'd0, 8'd4, 1'b0, 4'd0, 1, MSG_NACK),
      msg_row(REQ_TERM, 3'd0, 8'd9, 1'b0, 4'd0, 1, MSG_INFO),
      cfg_row(REG_UID, 16'hFFFF),
      cfg_row(REG_ROOT, 16'd1),
      cfg_row(REG_PORTS, 16'd2),
      msg_row(REQ_START, 3'd0, 8'd0, 1'b0, 4'd0, 2, MSG_SEARCH),
      msg_row(REQ_ACK, 3'd1, 8'd1, 1'b1, 4'd0),
      msg_row(REQ_NACK, 3'd0, 8'd1, 1'b0, 4'd0),
      msg_row(REQ_NACK, 3'd0, 8'd2, 1'b0, 4'd0),
      msg_row(REQ_NACK, 3'd1, 8'd2, 1'b0, 4'd0),
      msg_row(REQ_INFO, 3'd1, 8'd2, 1'b0, 4'd15),
      cfg_row(REG_PORTS, 16'd1),
      msg_row(REQ_START, 3'd0, 8'd0, 1'b0, 4'd0),
      msg_row(REQ_ACK, 3'd0, 8'd1, 1'b0, 4'd0),
      msg_row(REQ_NEWPHASE, 3'd0, 8'd255, 1'b0, 4'd0),
      msg_row(REQ_ACK, 3'd0, 8'd255, 1'b1, 4'd0),
      cfg_row(REG_PORTS, 16'd0),
      msg_row(REQ_START, 3'd0, 8'd0, 1'b0, 4'd0),
      cfg_row(REG_PORTS, 16'd15),
      msg_row(REQ_START, 3'd0, 8'd0, 1'b0, 4'd0, 8, MSG_SEARCH)
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        settle();
        write_reg(rows[i].code[1:0], rows[i].value);
      end else begin
        send_beat(rows[i].code, rows[i].src, rows[i].layer, rows[i].disc, rows[i].degree,
                  nb, ft);
        if (rows[i].want_beats != 0 &&
            (nb != rows[i].want_beats || ft != rows[i].want_type))
          report_mismatch($sformatf("row %0d gave %0d beats of type %0d", i, nb, ft));
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      idle_pct = idle_plan[ph];
      write_reg(REG_UID, 16'($urandom));
      write_reg(REG_ROOT, 16'(ph % 2 == 0));
      case (ph)
        0: write_reg(REG_PORTS, 16'd8);
        1: write_reg(REG_PORTS, 16'd1);
        default: write_reg(REG_PORTS, 16'($urandom_range(15)));
      endcase
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
        pick_item(ty, src, lay, disc, deg);
        send_beat(ty, src, lay, disc, deg, nb, ft);
      end
    end

    settle();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
